@@ design/speech_endpoint_detector_defines.svh @@
// assertion macros of the speech endpoint detector rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SPEECH_ENDPOINT_DETECTOR_DEFINES_SVH
`define SPEECH_ENDPOINT_DETECTOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sed_pkg.sv @@
// types, widths and codes of the speech endpoint detector
// no dependencies; used by the interfaces, the divider and the top level
`default_nettype none

package sed_pkg;

    localparam int MAX_BLOCK  = 4096;
    localparam int COUNT_BITS = 24;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 15;
    localparam int MS_W     = 32;
    localparam int THR_W    = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // block length counter must hold MAX_BLOCK itself
    localparam int BLK_W = $clog2(MAX_BLOCK + 1);
    // magnitude sum; also holds the smoothing numerator 10 * 32767
    localparam int SUM_W = (BLK_W + VOL_W > 19) ? (BLK_W + VOL_W) : 19;
    // divisor holds the block length and the constant ten
    localparam int DVS_W = (BLK_W > 4) ? BLK_W : 4;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [VOL_W-1:0]      VOL_MAX   = {VOL_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [MS_W-1:0]       MS_MAX    = {MS_W{1'b1}};
    localparam logic [DVS_W-1:0]      SMOOTH_DIV = DVS_W'(10);

    localparam logic [CFG_IDX_W-1:0] CFG_SIL_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEECH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd3;

    localparam logic [THR_W-1:0]      RST_SIL_THR    = THR_W'(500);
    localparam logic [COUNT_BITS-1:0] RST_MIN_SPEECH = COUNT_BITS'(8000);
    localparam logic [COUNT_BITS-1:0] RST_MIN_SIL    = COUNT_BITS'(24000);
    localparam logic [MS_W-1:0]       RST_TIMEOUT    = MS_W'(30000);

    typedef enum logic [1:0] {
        STAT_QUIET   = 2'd0,
        STAT_SPEECH  = 2'd1,
        STAT_AUTO    = 2'd2,
        STAT_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MEAN   = 5'b00010,
        ST_SMOOTH = 5'b00100,
        ST_UPD    = 5'b01000,
        ST_DEC    = 5'b10000
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ design/sed_in_if.sv @@
// input channel of the speech endpoint detector: samples and millisecond ticks
// depends on sed_pkg
`default_nettype none

interface sed_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [sed_pkg::SAMPLE_W-1:0] sample;
    logic                                block_end;

    modport source (output valid, output action, output sample, output block_end,
                    input ready);
    modport sink (input valid, input action, input sample, input block_end,
                  output ready);
endinterface

`default_nettype wire

@@ design/sed_out_if.sv @@
// result channel of the speech endpoint detector: one report per block
// depends on sed_pkg
`default_nettype none

interface sed_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [sed_pkg::VOL_W-1:0]        volume;
    logic [sed_pkg::COUNT_BITS-1:0]   speech_count;
    logic [sed_pkg::COUNT_BITS-1:0]   silence_count;
    logic [sed_pkg::MS_W-1:0]         ms_count;

    modport source (output valid, output status, output volume, output speech_count,
                    output silence_count, output ms_count, input ready);
    modport sink (input valid, input status, input volume, input speech_count,
                  input silence_count, input ms_count, output ready);
endinterface

`default_nettype wire

@@ design/speech_endpoint_detector.sv @@
// speech endpoint detector top level: block mean, smoothing, counters, status
// depends on sed_pkg, sed_in_if, sed_out_if, sed_div and the defines header
//
//  channel   dir  contents                                              transfer
//  audio     in   action, sample, block_end                             valid & ready
//  result    out  status, volume, speech_count, silence_count, ms_count valid & ready
//  cfg       in   cfg_we, cfg_index, cfg_data                           cfg_we high
//
// a tick or a sample that does not end a block leaves the detector idle and ready
// a block end runs the bit-serial divider to form the mean and then the smoothed
// volume; no smoothing divide is run when the old volume is zero
// audio is not taken while a block end is in work; a block end waits in the status
// step while the previous report is still untaken; rst_n clears the control state
// and counters and loads the default settings, not the length, mean or report registers
`default_nettype none
`include "speech_endpoint_detector_defines.svh"

module speech_endpoint_detector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    sed_in_if.sink                               audio,
    sed_out_if.source                            result,
    input  wire logic                            cfg_we,
    input  wire logic [sed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sed_pkg::CFG_W-1:0]       cfg_data
);

    sed_pkg::state_t                   state_reg, state_next;

    logic [sed_pkg::THR_W-1:0]         thr_reg;
    logic [sed_pkg::COUNT_BITS-1:0]    min_speech_reg;
    logic [sed_pkg::COUNT_BITS-1:0]    min_sil_reg;
    logic [sed_pkg::MS_W-1:0]          timeout_reg;

    logic [sed_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [sed_pkg::BLK_W-1:0]         cnt_reg, cnt_next;
    logic [sed_pkg::BLK_W-1:0]         len_reg, len_next;
    logic [sed_pkg::VOL_W-1:0]         mean_reg, mean_next;
    logic [sed_pkg::VOL_W-1:0]         vol_reg, vol_next;
    logic [sed_pkg::COUNT_BITS-1:0]    speech_reg, speech_next;
    logic [sed_pkg::COUNT_BITS-1:0]    sil_reg, sil_next;
    logic                              seen_reg, seen_next;
    logic [sed_pkg::MS_W-1:0]          ms_reg, ms_next;

    logic                              out_valid_reg, out_valid_next;
    sed_pkg::status_t                  out_status_reg, out_status_next;
    logic [sed_pkg::VOL_W-1:0]         out_vol_reg;
    logic [sed_pkg::COUNT_BITS-1:0]    out_speech_reg;
    logic [sed_pkg::COUNT_BITS-1:0]    out_sil_reg;
    logic [sed_pkg::MS_W-1:0]          out_ms_reg;
    logic                              out_load;

    sed_pkg::div_req_t                 div_req;
    sed_pkg::div_rsp_t                 div_rsp;

    logic                              in_xfer;
    logic [sed_pkg::SAMPLE_W-1:0]      raw;
    logic [sed_pkg::SAMPLE_W-1:0]      mag;
    logic [sed_pkg::SUM_W-1:0]         sum_add;
    logic [sed_pkg::BLK_W-1:0]         cnt_inc;
    logic                              blk_done;
    logic [sed_pkg::VOL_W-1:0]         mean_q;
    logic                              blk_quiet;
    logic [sed_pkg::COUNT_BITS:0]      speech_sum;
    logic [sed_pkg::COUNT_BITS:0]      sil_sum;

    sed_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_xfer = audio.valid && audio.ready;
    assign audio.ready = (state_reg == sed_pkg::ST_IDLE);

    // most negative sample wraps to 0x8000, which reads as 32768 unsigned
    assign raw     = audio.sample;
    assign mag     = raw[sed_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    assign sum_add = sum_reg + sed_pkg::SUM_W'(mag);
    assign cnt_inc = cnt_reg + 1'b1;
    assign blk_done = audio.block_end || (cnt_inc == sed_pkg::BLK_W'(sed_pkg::MAX_BLOCK));

    assign mean_q = (div_rsp.quotient > sed_pkg::SUM_W'(sed_pkg::VOL_MAX))
                    ? sed_pkg::VOL_MAX : div_rsp.quotient[sed_pkg::VOL_W-1:0];

    assign blk_quiet = {1'b0, mean_reg} < thr_reg;
    assign speech_sum = {1'b0, speech_reg} + (sed_pkg::COUNT_BITS + 1)'(len_reg);
    assign sil_sum    = {1'b0, sil_reg} + (sed_pkg::COUNT_BITS + 1)'(len_reg);

    assign out_load = (state_reg == sed_pkg::ST_DEC) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        mean_next   = mean_reg;
        vol_next    = vol_reg;
        speech_next = speech_reg;
        sil_next    = sil_reg;
        seen_next   = seen_reg;
        ms_next     = ms_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sum_add;
        div_req.divisor  = sed_pkg::DVS_W'(cnt_inc);
        out_status_next  = seen_reg ? sed_pkg::STAT_SPEECH : sed_pkg::STAT_QUIET;

        unique case (state_reg)
            sed_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (audio.action)
                    begin
                        if (ms_reg != sed_pkg::MS_MAX)
                            ms_next = ms_reg + 1'b1;
                    end
                    else if (blk_done)
                    begin
                        div_req.start = 1'b1;
                        len_next   = cnt_inc;
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = sed_pkg::ST_MEAN;
                    end
                    else
                    begin
                        sum_next = sum_add;
                        cnt_next = cnt_inc;
                    end
                end
            end
            sed_pkg::ST_MEAN:
            begin
                div_req.dividend = sed_pkg::SUM_W'(mean_q) * sed_pkg::SUM_W'(3)
                                 + sed_pkg::SUM_W'(vol_reg) * sed_pkg::SUM_W'(7);
                div_req.divisor  = sed_pkg::SMOOTH_DIV;
                if (div_rsp.done)
                begin
                    mean_next = mean_q;
                    if (vol_reg == '0)
                    begin
                        vol_next   = mean_q;
                        state_next = sed_pkg::ST_UPD;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = sed_pkg::ST_SMOOTH;
                    end
                end
            end
            sed_pkg::ST_SMOOTH:
            begin
                if (div_rsp.done)
                begin
                    vol_next   = div_rsp.quotient[sed_pkg::VOL_W-1:0];
                    state_next = sed_pkg::ST_UPD;
                end
            end
            sed_pkg::ST_UPD:
            begin
                if (blk_quiet)
                    sil_next = sil_sum[sed_pkg::COUNT_BITS] ? sed_pkg::COUNT_MAX
                                                            : sil_sum[sed_pkg::COUNT_BITS-1:0];
                else
                begin
                    speech_next = speech_sum[sed_pkg::COUNT_BITS]
                                  ? sed_pkg::COUNT_MAX : speech_sum[sed_pkg::COUNT_BITS-1:0];
                    sil_next    = '0;
                    seen_next   = 1'b1;
                end
                state_next = sed_pkg::ST_DEC;
            end
            sed_pkg::ST_DEC:
            begin
                // auto stop wins over timeout
                if (seen_reg && (speech_reg >= min_speech_reg) && (sil_reg >= min_sil_reg))
                    out_status_next = sed_pkg::STAT_AUTO;
                else if (ms_reg > timeout_reg)
                    out_status_next = sed_pkg::STAT_TIMEOUT;
                if (out_load)
                    state_next = sed_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sed_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sed_pkg::ST_IDLE;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            vol_reg        <= '0;
            speech_reg     <= '0;
            sil_reg        <= '0;
            seen_reg       <= 1'b0;
            ms_reg         <= '0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= sed_pkg::RST_SIL_THR;
            min_speech_reg <= sed_pkg::RST_MIN_SPEECH;
            min_sil_reg    <= sed_pkg::RST_MIN_SIL;
            timeout_reg    <= sed_pkg::RST_TIMEOUT;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            vol_reg       <= vol_next;
            speech_reg    <= speech_next;
            sil_reg       <= sil_next;
            seen_reg      <= seen_next;
            ms_reg        <= ms_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sed_pkg::CFG_SIL_THR:    thr_reg        <= cfg_data[sed_pkg::THR_W-1:0];
                    sed_pkg::CFG_MIN_SPEECH: min_speech_reg <= cfg_data[sed_pkg::COUNT_BITS-1:0];
                    sed_pkg::CFG_MIN_SIL:    min_sil_reg    <= cfg_data[sed_pkg::COUNT_BITS-1:0];
                    sed_pkg::CFG_TIMEOUT:    timeout_reg    <= cfg_data[sed_pkg::MS_W-1:0];
                    default:                 thr_reg        <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        mean_reg <= mean_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_vol_reg    <= vol_reg;
            out_speech_reg <= speech_reg;
            out_sil_reg    <= sil_reg;
            out_ms_reg     <= ms_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.volume        = out_vol_reg;
    assign result.speech_count  = out_speech_reg;
    assign result.silence_count = out_sil_reg;
    assign result.ms_count      = out_ms_reg;

    // divider results only show up while the sequencer waits for them
    `SED_ASSERT_NOW(a_div_done_busy, clk, rst_n, div_rsp.done, (state_reg == sed_pkg::ST_MEAN) || (state_reg == sed_pkg::ST_SMOOTH), "divider finished outside a divide state")
    // a sample that closes a block starts the mean
    `SED_ASSERT_NEXT(a_blk_start, clk, rst_n, in_xfer && !audio.action && blk_done, (state_reg == sed_pkg::ST_MEAN) && (sum_reg == '0) && (cnt_reg == '0), "block end did not start the mean")
    // partial block never reaches the forced end length
    `SED_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg < sed_pkg::BLK_W'(sed_pkg::MAX_BLOCK), "block length counter overran")
    // a report is only loaded once the counters have been updated
    `SED_ASSERT_NEXT(a_dec_after_upd, clk, rst_n, state_reg == sed_pkg::ST_UPD, state_reg == sed_pkg::ST_DEC, "update step not followed by status decision")

endmodule

`default_nettype wire

@@ design/sed_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on sed_pkg (widths, request and response structs)
`default_nettype none

module sed_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sed_pkg::div_req_t req,
    output sed_pkg::div_rsp_t      rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [sed_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [sed_pkg::DVS_W-1:0]         rem_reg, rem_next;
    logic [sed_pkg::SUM_W-1:0]         quo_reg, quo_next;
    logic [sed_pkg::DVS_W-1:0]         dvs_reg, dvs_next;
    logic [sed_pkg::DVS_W:0]           trial;
    logic                              fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[sed_pkg::SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? sed_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                            : trial[sed_pkg::DVS_W-1:0];
            quo_next = {quo_reg[sed_pkg::SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == sed_pkg::STEP_W'(sed_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

@@ sim/tb_speech_endpoint_detector.sv @@
`timescale 1ns / 100ps
// testbench of the speech endpoint detector: a directed stimulus table, then random blocks
// depends on sed_pkg, sed_in_if, sed_out_if and speech_endpoint_detector
module tb_speech_endpoint_detector;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int SEG_ITEMS      = 145;
    localparam int NUM_SEGS       = 6;
    localparam int DIR_ROWS       = 17;
    localparam int NO_CFG         = -1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef struct packed {
        sed_pkg::status_t               status;
        logic [sed_pkg::VOL_W-1:0]      volume;
        logic [sed_pkg::COUNT_BITS-1:0] speech_count;
        logic [sed_pkg::COUNT_BITS-1:0] silence_count;
        logic [sed_pkg::MS_W-1:0]       ms_count;
    } report_t;

    typedef struct packed {
        logic [sed_pkg::THR_W-1:0]      thr;
        logic [sed_pkg::COUNT_BITS-1:0] min_speech;
        logic [sed_pkg::COUNT_BITS-1:0] min_silence;
        logic [sed_pkg::MS_W-1:0]       timeout;
    } det_cfg_t;

    typedef struct packed {
        int                             cfg_sel;
        logic                           act;
        logic [sed_pkg::SAMPLE_W-1:0]   smp;
        logic                           bend;
        int                             reps;
        bit                             typed;
        report_t                        want;
    } stim_row_t;

    localparam report_t NO_REPORT = '{sed_pkg::STAT_QUIET, 15'd0, 24'd0, 24'd0, 32'd0};

    localparam det_cfg_t DIR_CFG [3] = '{
        '{16'd0, 24'd0, 24'd0, 32'd0},
        '{16'h8000, 24'hffffff, 24'hffffff, 32'd0},
        '{16'd500, 24'hffffff, 24'hffffff, 32'hffffffff}
    };

    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        '{NO_CFG, ACT_SAMPLE, 16'h0000, 1'b1, 1, 1'b1,
          '{sed_pkg::STAT_QUIET, 15'd0, 24'd0, 24'd1, 32'd0}},
        // most negative sample, mean clamped
        '{NO_CFG, ACT_SAMPLE, 16'h8000, 1'b1, 1, 1'b1,
          '{sed_pkg::STAT_SPEECH, 15'h7fff, 24'd1, 24'd0, 32'd0}},
        '{NO_CFG, ACT_SAMPLE, 16'h7fff, 1'b1, 1, 1'b1,
          '{sed_pkg::STAT_SPEECH, 15'h7fff, 24'd2, 24'd0, 32'd0}},
        // ticks ignore sample and end flag
        '{NO_CFG, ACT_TICK, 16'hffff, 1'b1, 3, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_SAMPLE, 16'd499, 1'b1, 1, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_SAMPLE, 16'd500, 1'b1, 1, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_SAMPLE, 16'hfe0c, 1'b1, 1, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_SAMPLE, 16'hffff, 1'b0, 3, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_SAMPLE, 16'h0001, 1'b1, 1, 1'b0, NO_REPORT},
        // tick inside a block leaves the block alone
        '{NO_CFG, ACT_SAMPLE, 16'h5555, 1'b0, 5, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_TICK, 16'h0000, 1'b1, 1, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_SAMPLE, 16'haaaa, 1'b1, 1, 1'b0, NO_REPORT},
        // all limits zero: auto stop beats timeout
        '{0, ACT_SAMPLE, 16'h0000, 1'b1, 1, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_TICK, 16'h0000, 1'b0, 1, 1'b0, NO_REPORT},
        // threshold above any mean, timeout at zero
        '{1, ACT_SAMPLE, 16'h7fff, 1'b1, 1, 1'b0, NO_REPORT},
        '{2, ACT_SAMPLE, 16'h8000, 1'b1, 1, 1'b0, NO_REPORT},
        '{NO_CFG, ACT_SAMPLE, 16'd1234, 1'b1, 1, 1'b0, NO_REPORT}
    };

    logic clk;
    logic rst_n;
    logic                          cfg_we;
    logic [sed_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sed_pkg::CFG_W-1:0]     cfg_data;

    sed_in_if  audio_ch ();
    sed_out_if result_ch ();

    speech_endpoint_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .audio     (audio_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    det_cfg_t                       live_cfg;
    longint unsigned                blk_sum;
    int unsigned                    blk_len;
    logic [sed_pkg::VOL_W-1:0]      vol_q;
    logic [sed_pkg::COUNT_BITS-1:0] speech_total_q;
    logic [sed_pkg::COUNT_BITS-1:0] silence_run_q;
    bit                             speech_seen_q;
    logic [sed_pkg::MS_W-1:0]       ms_q;

    report_t pending_reports [$];
    report_t got_want;
    int      fail_count = 0;
    int      send_gap_pct;
    int      recv_stall_pct;
    int      idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic detector_step(input logic act, input logic [sed_pkg::SAMPLE_W-1:0] smp,
                                 input logic bend, output bit produced, output report_t rep);
        logic [16:0]     mag;
        longint unsigned mean;
        longint unsigned acc;
        produced = 1'b0;
        rep = NO_REPORT;
        if (act == ACT_TICK)
        begin
            if (ms_q != sed_pkg::MS_MAX)
                ms_q = ms_q + 1'b1;
        end
        else
        begin
            mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
            blk_sum += mag;
            blk_len++;
            if (bend || blk_len >= sed_pkg::MAX_BLOCK)
            begin
                mean = blk_sum / blk_len;
                if (mean > sed_pkg::VOL_MAX)
                    mean = sed_pkg::VOL_MAX;
                if (vol_q == 0)
                    vol_q = sed_pkg::VOL_W'(mean);
                else
                    vol_q = sed_pkg::VOL_W'((3 * mean + 7 * longint'(vol_q)) / 10);
                if (mean < live_cfg.thr)
                begin
                    acc = longint'(silence_run_q) + blk_len;
                    silence_run_q = (acc > sed_pkg::COUNT_MAX) ? sed_pkg::COUNT_MAX
                                                               : sed_pkg::COUNT_BITS'(acc);
                end
                else
                begin
                    acc = longint'(speech_total_q) + blk_len;
                    speech_total_q = (acc > sed_pkg::COUNT_MAX) ? sed_pkg::COUNT_MAX
                                                                : sed_pkg::COUNT_BITS'(acc);
                    silence_run_q = '0;
                    speech_seen_q = 1'b1;
                end
                blk_sum = 0;
                blk_len = 0;
                if (speech_seen_q && speech_total_q >= live_cfg.min_speech &&
                    silence_run_q >= live_cfg.min_silence)
                    rep.status = sed_pkg::STAT_AUTO;
                else if (ms_q > live_cfg.timeout)
                    rep.status = sed_pkg::STAT_TIMEOUT;
                else
                    rep.status = speech_seen_q ? sed_pkg::STAT_SPEECH : sed_pkg::STAT_QUIET;
                rep.volume = vol_q;
                rep.speech_count = speech_total_q;
                rep.silence_count = silence_run_q;
                rep.ms_count = ms_q;
                produced = 1'b1;
            end
        end
    endtask

    // drives one item, waits for its transfer and records what it should cause
    task automatic push_audio(input logic act, input logic [sed_pkg::SAMPLE_W-1:0] smp,
                              input logic bend, input bit typed, input report_t want);
        bit      produced;
        report_t rep;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            audio_ch.valid <= 1'b0;
            @(posedge clk);
        end
        audio_ch.valid <= 1'b1;
        audio_ch.action <= act;
        audio_ch.sample <= smp;
        audio_ch.block_end <= bend;
        @(posedge clk);
        while (!audio_ch.ready)
            @(posedge clk);
        detector_step(act, smp, bend, produced, rep);
        if (produced)
            pending_reports.push_back(typed ? want : rep);
    endtask

    // block idle: every report back and the last item worked off
    task automatic end_phase();
        audio_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input det_cfg_t s);
        cfg_we <= 1'b1;
        cfg_index <= sed_pkg::CFG_SIL_THR;
        cfg_data <= sed_pkg::CFG_W'(s.thr);
        @(posedge clk);
        cfg_index <= sed_pkg::CFG_MIN_SPEECH;
        cfg_data <= sed_pkg::CFG_W'(s.min_speech);
        @(posedge clk);
        cfg_index <= sed_pkg::CFG_MIN_SIL;
        cfg_data <= sed_pkg::CFG_W'(s.min_silence);
        @(posedge clk);
        cfg_index <= sed_pkg::CFG_TIMEOUT;
        cfg_data <= sed_pkg::CFG_W'(s.timeout);
        @(posedge clk);
        cfg_we <= 1'b0;
        live_cfg = s;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("report transfer with no report expected");
                    fail_count++;
                end
                else
                begin
                    got_want = pending_reports.pop_front();
                    if (result_ch.status !== got_want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               got_want.status, result_ch.status);
                        fail_count++;
                    end
                    if (result_ch.volume !== got_want.volume)
                    begin
                        $error("volume mismatch: expected %0d, got %0d",
                               got_want.volume, result_ch.volume);
                        fail_count++;
                    end
                    if (result_ch.speech_count !== got_want.speech_count)
                    begin
                        $error("speech_count mismatch: expected %0d, got %0d",
                               got_want.speech_count, result_ch.speech_count);
                        fail_count++;
                    end
                    if (result_ch.silence_count !== got_want.silence_count)
                    begin
                        $error("silence_count mismatch: expected %0d, got %0d",
                               got_want.silence_count, result_ch.silence_count);
                        fail_count++;
                    end
                    if (result_ch.ms_count !== got_want.ms_count)
                    begin
                        $error("ms_count mismatch: expected %0d, got %0d",
                               got_want.ms_count, result_ch.ms_count);
                        fail_count++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // counts cycles with no transfer on either channel and stops the run at the watchdog limit
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((audio_ch.valid && audio_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        det_cfg_t                     seg_cfg;
        stim_row_t                    row;
        int                           seg_items;
        int                           blk_n;
        int                           loudness;
        int                           m;
        int                           thr_top;
        logic [sed_pkg::SAMPLE_W-1:0] smp_v;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sed_pkg::CFG_SIL_THR;
        cfg_data = '0;
        audio_ch.valid = 1'b0;
        audio_ch.action = ACT_SAMPLE;
        audio_ch.sample = '0;
        audio_ch.block_end = 1'b0;
        live_cfg = '{sed_pkg::RST_SIL_THR, sed_pkg::RST_MIN_SPEECH, sed_pkg::RST_MIN_SIL,
                     sed_pkg::RST_TIMEOUT};
        blk_sum = 0;
        blk_len = 0;
        vol_q = '0;
        speech_total_q = '0;
        silence_run_q = '0;
        speech_seen_q = 1'b0;
        ms_q = '0;
        send_gap_pct = 12;
        recv_stall_pct = 64;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = DIR_TAB[r];
            if (row.cfg_sel != NO_CFG)
            begin
                end_phase();
                apply_settings(DIR_CFG[row.cfg_sel]);
            end
            for (int k = 0; k < row.reps; k++)
                push_audio(row.act, row.smp, row.bend, row.typed, row.want);
        end

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            end_phase();
            seg_cfg.thr = ($urandom_range(0, 3) == 0)
                          ? sed_pkg::THR_W'($urandom_range(0, 32768))
                          : sed_pkg::THR_W'($urandom_range(0, 2000));
            seg_cfg.min_speech = sed_pkg::COUNT_BITS'($urandom_range(0, 400));
            seg_cfg.min_silence = sed_pkg::COUNT_BITS'($urandom_range(0, 200));
            seg_cfg.timeout = sed_pkg::MS_W'($urandom_range(0, 300));
            case (seg)
                0: seg_cfg = '{16'h8000, 24'd0, 24'hffffff, 32'hffffffff};
                2: seg_cfg = '{16'd0, 24'hffffff, 24'd0, 32'd0};
                5: seg_cfg = '{sed_pkg::RST_SIL_THR, sed_pkg::RST_MIN_SPEECH,
                               sed_pkg::RST_MIN_SIL, sed_pkg::RST_TIMEOUT};
                default: ;
            endcase
            apply_settings(seg_cfg);
            send_gap_pct = (seg < 2) ? 12 : (seg < 4) ? 64 : 0;
            recv_stall_pct = (seg < 2) ? 64 : (seg < 4) ? 12 : 0;

            seg_items = 0;
            while (seg_items < SEG_ITEMS)
            begin
                blk_n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40)
                                                    : $urandom_range(1, 6);
                loudness = $urandom_range(0, 3);
                thr_top = int'(live_cfg.thr) + int'(live_cfg.thr) / 4 + 1;
                if (thr_top > 32768)
                    thr_top = 32768;
                for (int k = 0; k < blk_n; k++)
                begin
                    // stray tick with random payload
                    if ($urandom_range(0, 4) == 0)
                    begin
                        push_audio(ACT_TICK, sed_pkg::SAMPLE_W'($urandom), 1'($urandom), 1'b0,
                                   NO_REPORT);
                        seg_items++;
                    end
                    case (loudness)
                        0: m = $urandom_range(0, thr_top);
                        1: m = $urandom_range(0, 32768);
                        2: m = (live_cfg.thr < 3) ? $urandom_range(0, 4)
                                                  : $urandom_range(live_cfg.thr - 2,
                                                                   live_cfg.thr + 2);
                        default: m = -1;
                    endcase
                    if (m > 32768)
                        m = 32768;
                    if (m < 0)
                    begin
                        case ($urandom_range(0, 4))
                            0: smp_v = 16'h8000;
                            1: smp_v = 16'h7fff;
                            2: smp_v = 16'h0000;
                            3: smp_v = 16'hffff;
                            default: smp_v = 16'h8001;
                        endcase
                    end
                    else
                        smp_v = $urandom_range(0, 1) ? sed_pkg::SAMPLE_W'(-m)
                                                     : sed_pkg::SAMPLE_W'(m);
                    push_audio(ACT_SAMPLE, smp_v, k == blk_n - 1, 1'b0, NO_REPORT);
                    seg_items++;
                end
            end
        end

        end_phase();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ speech_endpoint_detector.f @@
+incdir+design
design/sed_pkg.sv
design/sed_in_if.sv
design/sed_out_if.sv
design/sed_div.sv
design/speech_endpoint_detector.sv
sim/tb_speech_endpoint_detector.sv
